FILE: sv/btnpc_pkg.sv
// Types and constants shared by the button press classifier files.
package btnpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [TimeW-1:0] time_ms_t;
  typedef logic [CfgW-1:0]  cfg_ms_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } press_event_t;

  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PRESS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_GAP = 2'd2;

  localparam cfg_ms_t LONG_PRESS_RST = 16'd700;
  localparam cfg_ms_t MIN_PRESS_RST  = 16'd30;
  localparam cfg_ms_t DOUBLE_GAP_RST = 16'd300;

endpackage

FILE: sv/btnpc_if.sv
// Valid/ready channel interfaces for polls and classified events.
interface btnpc_in_if import btnpc_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     button_level;
  time_ms_t now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface btnpc_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink   (input valid, input press_event, output ready);
endinterface

FILE: sv/button_press_classifier.sv
// Top level: classifies polled button samples into short, long and double presses.
//
// Usage:
//   in_ch carries one poll per transaction: button_level (0 pressed) and
//   now_ms, a wrapping millisecond timestamp. out_ch returns exactly one
//   press_event per poll, in order: 0 none, 1 short, 2 long, 3 double.
//   cfg_we/cfg_index/cfg_wdata write long_press_ms (0), min_press_ms (1)
//   and double_gap_ms (2); other indexes are ignored. Write only while idle.
// Result: registered, and valid in the cycle after the input transaction.
// Throughput: one poll per cycle unless out_ch stalls; the classifier state
//   and all compares sit between the input handshake and a single result register.
// Stall: in_ch.ready stays high while the result register is empty or
//   being drained, so a stalled receiver holds one result and the input
//   waits only until out_ch.ready returns.
// Reset: synchronous, active low; thresholds return to 700/30/300 ms,
//   the button reads as released and no click is pending.
module button_press_classifier import btnpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  btnpc_in_if.sink            in_ch,
  btnpc_out_if.source         out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_wdata
);

  cfg_ms_t      long_press_r, min_press_r, double_gap_r;
  logic         last_level_r;
  time_ms_t     press_start_r, pending_r;
  logic         awaiting_r, long_rep_r;
  logic         out_valid_r;
  press_event_t event_r;

  logic         in_fire;
  logic         press_edge, release_edge;
  time_ms_t     start_sel, held, age;
  logic         long_rep_sel, long_fire, counted, pair, short_fire;
  logic         awaiting_nxt, long_rep_nxt;
  time_ms_t     press_start_nxt, pending_nxt;
  press_event_t event_nxt;

  assign in_ch.ready        = !out_valid_r || out_ch.ready;
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.press_event = event_r;

  always_comb begin
    press_edge   = !in_ch.button_level && last_level_r;
    release_edge = in_ch.button_level && !last_level_r;
    start_sel    = press_edge ? in_ch.now_ms : press_start_r;
    long_rep_sel = press_edge ? 1'b0 : long_rep_r;
    held         = in_ch.now_ms - start_sel;
    age          = in_ch.now_ms - pending_r;

    long_fire    = !in_ch.button_level && !long_rep_sel &&
                   (held >= time_ms_t'(long_press_r));
    long_rep_nxt = long_rep_sel || long_fire;

    counted      = release_edge && !long_rep_sel && (held >= time_ms_t'(min_press_r));
    pair         = counted && awaiting_r && (age < time_ms_t'(double_gap_r));

    awaiting_nxt    = awaiting_r;
    pending_nxt     = pending_r;
    press_start_nxt = start_sel;
    if (pair) begin
      awaiting_nxt = 1'b0;
    end else if (counted) begin
      awaiting_nxt = 1'b1;
      pending_nxt  = in_ch.now_ms;
    end

    // a fresh pending click has age zero and never times out in the same poll
    short_fire = awaiting_nxt && !counted && (age > time_ms_t'(double_gap_r));
    if (short_fire) begin
      awaiting_nxt = 1'b0;
    end

    if (short_fire) begin
      event_nxt = EV_SHORT;
    end else if (pair) begin
      event_nxt = EV_DOUBLE;
    end else if (long_fire) begin
      event_nxt = EV_LONG;
    end else begin
      event_nxt = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      min_press_r  <= MIN_PRESS_RST;
      double_gap_r <= DOUBLE_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        CFG_MIN_PRESS:  min_press_r  <= cfg_wdata;
        CFG_DOUBLE_GAP: double_gap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b1;
      press_start_r <= '0;
      pending_r     <= '0;
      awaiting_r    <= 1'b0;
      long_rep_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        last_level_r  <= in_ch.button_level;
        press_start_r <= press_start_nxt;
        pending_r     <= pending_nxt;
        awaiting_r    <= awaiting_nxt;
        long_rep_r    <= long_rep_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_r <= event_nxt;
    end
  end

  a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && event_nxt == EV_DOUBLE |=> !awaiting_r)
    else $error("double press left a click pending");

  a_short_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && event_nxt == EV_SHORT |=> !awaiting_r)
    else $error("short press left a click pending");

  a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && event_nxt == EV_LONG |=> long_rep_r && !last_level_r)
    else $error("long press not marked as reported");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire))
    else $error("result appeared without an input transaction");

  a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.button_level |-> event_nxt != EV_LONG)
    else $error("long press reported while released");

endmodule

FILE: test/button_press_classifier_tb.sv
// Testbench for button_press_classifier: directed and random polls checked against a predictor.
`timescale 1ns / 1ps

module button_press_classifier_tb;
  import btnpc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;

  btnpc_in_if  in_ch ();
  btnpc_out_if out_ch ();

  button_press_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state and thresholds
  cfg_ms_t  thr_long_ms;
  cfg_ms_t  thr_min_ms;
  cfg_ms_t  thr_gap_ms;
  logic     prev_level;
  time_ms_t press_start_ms;
  time_ms_t click_ms;
  logic     click_pending;
  logic     long_done;

  press_event_t expected_events[$];
  time_ms_t clock_ms;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned polls_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned kind_count[4];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("button_press_classifier: mismatch");
    $finish;
  end

  task automatic reset_model();
    thr_long_ms    = LONG_PRESS_RST;
    thr_min_ms     = MIN_PRESS_RST;
    thr_gap_ms     = DOUBLE_GAP_RST;
    prev_level     = 1'b1;
    press_start_ms = '0;
    click_ms       = '0;
    click_pending  = 1'b0;
    long_done      = 1'b0;
  endtask

  function automatic press_event_t classify_poll(logic level, time_ms_t now);
    press_event_t ev;
    time_ms_t held;
    time_ms_t age;
    ev = EV_NONE;
    if (!level && prev_level) begin
      press_start_ms = now;
      long_done = 1'b0;
    end
    held = now - press_start_ms;
    if (!level && !long_done && held >= time_ms_t'(thr_long_ms)) begin
      ev = EV_LONG;
      long_done = 1'b1;
    end
    if (level && !prev_level && !long_done && held >= time_ms_t'(thr_min_ms)) begin
      age = now - click_ms;
      if (click_pending && age < time_ms_t'(thr_gap_ms)) begin
        ev = EV_DOUBLE;
        click_pending = 1'b0;
      end else begin
        click_pending = 1'b1;
        click_ms = now;
      end
    end
    age = now - click_ms;
    if (click_pending && age > time_ms_t'(thr_gap_ms)) begin
      ev = EV_SHORT;
      click_pending = 1'b0;
    end
    prev_level = level;
    return ev;
  endfunction

  // receiver: random stall, check each result transaction
  initial begin
    press_event_t want;
    press_event_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = press_event_t'(out_ch.press_event);
        results_checked++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d with nothing outstanding", got);
        end else begin
          want = expected_events.pop_front();
          kind_count[want]++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %s, got %0d", results_checked, want.name(),
                       got);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_poll(input logic level, input time_ms_t now);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_level <= level;
    in_ch.now_ms       <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_events.push_back(classify_poll(level, now));
    polls_sent++;
  endtask

  task automatic poll_after(input logic level, input time_ms_t dt);
    clock_ms = clock_ms + dt;
    send_poll(level, clock_ms);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input cfg_ms_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_PRESS: thr_long_ms = data;
      CFG_MIN_PRESS:  thr_min_ms  = data;
      CFG_DOUBLE_GAP: thr_gap_ms  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_thresholds(input cfg_ms_t long_ms, input cfg_ms_t min_ms,
                                input cfg_ms_t gap_ms);
    wait_idle();
    write_reg(CFG_LONG_PRESS, long_ms);
    write_reg(CFG_MIN_PRESS, min_ms);
    write_reg(CFG_DOUBLE_GAP, gap_ms);
  endtask

  function automatic time_ms_t near_ms(cfg_ms_t thr);
    case ($urandom_range(4))
      0: return time_ms_t'(thr) - 1;
      1: return time_ms_t'(thr);
      2: return time_ms_t'(thr) + 1;
      default: return $urandom_range(0, 2 * thr + 2);
    endcase
  endfunction

  task automatic test_click_patterns();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_poll(1'b1, 32'h0000_0000);
    send_poll(1'b1, 32'hFFFF_FFFF);
    // single click polled exactly at and just past the gap, aging out just past it
    send_poll(1'b0, 32'd1000);
    send_poll(1'b1, 32'd1050);
    send_poll(1'b1, 32'd1350);
    send_poll(1'b1, 32'd1351);
    // bounce below the minimum, then a double click
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2029);
    send_poll(1'b0, 32'd2100);
    send_poll(1'b1, 32'd2130);
    send_poll(1'b0, 32'd2200);
    send_poll(1'b1, 32'd2250);
    // long hold around its threshold
    send_poll(1'b0, 32'd3000);
    send_poll(1'b0, 32'd3699);
    send_poll(1'b0, 32'd3700);
    send_poll(1'b0, 32'd3800);
    send_poll(1'b1, 32'd3900);
    // second release exactly at the gap replaces the pending click
    send_poll(1'b0, 32'd4000);
    send_poll(1'b1, 32'd4040);
    send_poll(1'b0, 32'd4200);
    send_poll(1'b1, 32'd4340);
    send_poll(1'b1, 32'd4641);
    // press across the timestamp wrap
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'h0000_0030);
    send_poll(1'b1, 32'h0000_0200);
  endtask

  task automatic test_threshold_extremes();
    set_thresholds('0, '0, '0);
    write_reg(CFG_UNUSED, '1);
    send_poll(1'b0, 32'd10);
    send_poll(1'b1, 32'd20);
    set_thresholds('1, '0, '0);
    send_poll(1'b0, 32'd100);
    send_poll(1'b1, 32'd100);
    send_poll(1'b1, 32'd101);
    send_poll(1'b0, 32'd110);
    send_poll(1'b1, 32'd110);
    send_poll(1'b1, 32'd110);
    // short outranks a long firing in the same poll
    set_thresholds(16'd100, '0, 16'd5);
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd10);
    send_poll(1'b0, 32'd12);
    send_poll(1'b0, 32'd200);
    set_thresholds('1, '1, '1);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b1, 32'd66535);
    send_poll(1'b0, 32'd70000);
    send_poll(1'b1, 32'd135535);
    send_poll(1'b0, 32'd140000);
    send_poll(1'b0, 32'd205535);
    send_poll(1'b1, 32'd205600);
  endtask

  task automatic press_gesture();
    time_ms_t hold;
    time_ms_t part;
    int unsigned mid_polls;
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(3) == 0) poll_after(1'($urandom_range(1)), $urandom());
      else poll_after(1'($urandom_range(1)), $urandom_range(0, 50));
    end else begin
      case ($urandom_range(3))
        0: hold = near_ms(thr_min_ms);
        1: hold = near_ms(thr_long_ms);
        default: hold = $urandom_range(thr_min_ms, thr_long_ms + 10);
      endcase
      if ($urandom_range(1)) poll_after(1'b0, $urandom_range(0, thr_gap_ms));
      else poll_after(1'b0, near_ms(thr_gap_ms));
      mid_polls = $urandom_range(0, 2);
      repeat (mid_polls) begin
        part = $urandom_range(0, hold);
        poll_after(1'b0, part);
        hold = hold - part;
      end
      poll_after(1'b1, hold);
      if ($urandom_range(99) < 30) poll_after(1'b1, near_ms(thr_gap_ms));
    end
  endtask

  task automatic test_random_gestures(input int unsigned polls, input int unsigned idle_pct,
                                      input int unsigned stall_pct, input cfg_ms_t long_ms,
                                      input cfg_ms_t min_ms, input cfg_ms_t gap_ms);
    int unsigned first;
    set_thresholds(long_ms, min_ms, gap_ms);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    clock_ms = $urandom();
    first = polls_sent;
    while (polls_sent - first < polls) press_gesture();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.button_level <= 1'b1;
    in_ch.now_ms       <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_LONG_PRESS;
    cfg_wdata          <= '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    polls_sent      = 0;
    results_checked = 0;
    mismatches      = 0;
    kind_count      = '{default: 0};
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_click_patterns();
    test_threshold_extremes();
    test_random_gestures(210, 0, 0, cfg_ms_t'($urandom_range(1, 1500)),
                         cfg_ms_t'($urandom_range(0, 60)), cfg_ms_t'($urandom_range(1, 500)));
    test_random_gestures(210, 81, 0, cfg_ms_t'($urandom_range(1, 1500)),
                         cfg_ms_t'($urandom_range(0, 60)), cfg_ms_t'($urandom_range(1, 500)));
    test_random_gestures(210, 0, 81, cfg_ms_t'($urandom_range(1, 1500)),
                         cfg_ms_t'($urandom_range(0, 60)), cfg_ms_t'($urandom_range(1, 500)));
    test_random_gestures(210, 33, 33, cfg_ms_t'($urandom_range(1, 1500)),
                         cfg_ms_t'($urandom_range(0, 60)), cfg_ms_t'($urandom_range(1, 500)));
    test_random_gestures(60, 33, 33, '1, '0, '1);
    wait_idle();

    mismatches += expected_events.size();
    $display("polls sent %0d, results checked %0d, mismatches %0d",
             polls_sent, results_checked, mismatches);
    $display("events seen: none %0d, short %0d, long %0d, double %0d",
             kind_count[EV_NONE], kind_count[EV_SHORT], kind_count[EV_LONG],
             kind_count[EV_DOUBLE]);
    if (mismatches == 0) begin
      $display("button_press_classifier: match");
    end else begin
      $display("button_press_classifier: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/btnpc_pkg.sv
sv/btnpc_if.sv
sv/button_press_classifier.sv
test/button_press_classifier_tb.sv
